@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL; the top-level counter includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LPOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: when ante holds, cons must hold too.
`define LPOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next cycle.
`define LPOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpoc_pkg.sv @@
package lpoc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pattern;
    logic [LEN_W-1:0]            length;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic is_nl;
    logic last;
    logic hit;
  } tally_ctrl_t;

  typedef struct packed {
    logic [15:0] line_matches;
    logic [31:0] book_matches;
    logic        book_done;
  } result_t;

endpackage

@@ hdl/lpoc_cfg.sv @@
module lpoc_cfg
  import lpoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [63:0] pat_low_r;
  logic [63:0] pat_high_r;
  logic [4:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_r      <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pat_low_r  <= cfg_data;
        REG_PATTERN_HIGH: pat_high_r <= cfg_data;
        REG_PATTERN_LEN:  len_r      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // A length of zero means one byte; anything above the maximum is clamped.
  always_comb begin
    cfg.pattern = {pat_high_r, pat_low_r};
    if (len_r == 5'd0) begin
      cfg.length = LEN_W'(1);
    end else if (LEN_W'(len_r) > LEN_W'(MAX_PATTERN)) begin
      cfg.length = LEN_W'(MAX_PATTERN);
    end else begin
      cfg.length = LEN_W'(len_r);
    end
  end

endmodule

@@ hdl/lpoc_window.sv @@
module lpoc_window
  import lpoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output logic       hit
);

  logic [MAX_PATTERN-2:0][7:0] recent_r;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [LEN_W-1:0]            pidx [MAX_PATTERN];

  // Window position 0 is the byte being scanned, position i the byte i back.
  always_comb begin
    win[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win[i] = recent_r[i-1];
    end
  end

  // The last pattern byte lines up with the newest byte.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx[i] = cfg.length - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < cfg.length) && (win[i] != cfg.pattern[pidx[i][IDX_W-1:0]])) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
    end else if (shift_en) begin
      recent_r <= {recent_r[MAX_PATTERN-3:0], data_byte};
    end
  end

endmodule

@@ hdl/lpoc_tally.sv @@
module lpoc_tally
  import lpoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tally_ctrl_t      ctrl,
  input  logic [LEN_W-1:0] length,
  output result_t          res
);

  logic [LEN_W-1:0] free_r, free_nxt, free_inc;
  logic [15:0]      line_r, line_nxt, line_scan;
  logic [31:0]      book_r, book_nxt, book_scan;
  logic             matched;

  always_comb begin
    free_inc  = (free_r < LEN_W'(MAX_PATTERN)) ? free_r + LEN_W'(1) : free_r;
    matched   = !ctrl.is_nl && ctrl.hit && (free_inc >= length);
    line_scan = (matched && line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
    book_scan = (matched && book_r != 32'hFFFF_FFFF) ? book_r + 32'd1 : book_r;

    free_nxt = free_r;
    line_nxt = line_r;
    book_nxt = book_r;
    if (ctrl.fire) begin
      free_nxt = ctrl.is_nl ? free_r : (matched ? '0 : free_inc);
      line_nxt = line_scan;
      book_nxt = book_scan;
      if (ctrl.is_nl || ctrl.last) begin
        free_nxt = '0;
        line_nxt = '0;
      end
      if (ctrl.last) begin
        book_nxt = '0;
      end
    end

    res.line_matches = line_scan;
    res.book_matches = book_scan;
    res.book_done    = ctrl.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      line_r <= '0;
      book_r <= '0;
    end else begin
      free_r <= free_nxt;
      line_r <= line_nxt;
      book_r <= book_nxt;
    end
  end

endmodule

@@ hdl/line_pattern_occurrence_counter.sv @@
// Line pattern occurrence counter.
// Text arrives one byte per input transaction (in_data_byte, in_end_of_book).
// A newline byte closes a line; in_end_of_book marks the final byte of a book.
// Within each line the block counts non-overlapping, leftmost-first matches of
// the pattern in the configuration registers (1 to 16 bytes). The user writes
// them via cfg_we / cfg_index / cfg_data only while the block is idle; it does not enforce this.
// Each newline, and each end-of-book byte, produces one output transaction
// with the line count, the running book count and book_done; other bytes
// produce none. Both counts saturate.
// Throughput: one byte per clock while no byte waits for the output slot. A
// byte in the input register is scanned combinationally, and its result is
// written into the output register on the edge at which that byte fires.
// When the receiver stalls with a result pending, bytes that produce no
// result keep flowing; a byte that needs the output slot waits in the input
// register and in_ready drops until the slot frees.
// Synchronous active-low reset empties both registers, clears the tallies and
// the byte window, and restores pattern length one with an all-zero pattern.
`include "assert_macros.svh"

module line_pattern_occurrence_counter
  import lpoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_book,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_line_matches,
  output logic [31:0]           out_book_matches,
  output logic                  out_book_done,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  tally_ctrl_t ctrl;
  result_t     res;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eob_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       is_nl, needs_out, fire, hit;

  // The scan stage fires unless it owes a result and the output slot is full
  // and not being drained this cycle.
  assign is_nl     = (in_byte_r == NEWLINE_CODE);
  assign needs_out = in_valid_r && (is_nl || in_eob_r);
  assign fire      = in_valid_r && (!needs_out || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;

  assign ctrl.fire  = fire;
  assign ctrl.is_nl = is_nl;
  assign ctrl.last  = in_eob_r;
  assign ctrl.hit   = hit;

  lpoc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Newlines are never scanned and never enter the window.
  lpoc_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (fire && !is_nl),
    .data_byte (in_byte_r),
    .cfg       (cfg),
    .hit       (hit)
  );

  lpoc_tally u_tally (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .length (cfg.length),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_eob_r  <= in_end_of_book;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && needs_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && needs_out) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_matches = out_r.line_matches;
  assign out_book_matches = out_r.book_matches;
  assign out_book_done    = out_r.book_done;

  `LPOC_ASSERT_IMP(a_stall_blocks, needs_out && out_valid_r && !out_ready, !in_ready,
                   "input accepted while its result had no room")
  `LPOC_ASSERT_NXT(a_result_shown, fire && needs_out, out_valid,
                   "line result was not presented")
  `LPOC_ASSERT_NXT(a_no_spurious, !(fire && needs_out) && !out_valid_r, !out_valid,
                   "result appeared without a closing byte")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Testbench for the line pattern occurrence counter.
// A driver and two monitors, all clocked always blocks, surround the block. The
// driver feeds input transactions from a queue of pending text bytes. The input
// monitor feeds every accepted byte into a predictor that keeps its own copy of
// the byte window, the free-byte count and the line and book tallies. The output
// monitor compares each result transaction with the oldest predicted result.
module tb;
  import lpoc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  // The block turns a byte into a result within one register stage. The settling
  // time covers a byte that is still in flight but makes no result.
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int PHASE_ITEMS   = 90;
  localparam int PHASE_COUNT   = 9;

  // Index 3 is not mapped to any register. Writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;

  // Settings for each random phase. Entry 0 is the rightmost one. The lengths
  // include zero, which the block treats as one, and values above sixteen,
  // which it clamps to sixteen.
  localparam logic [PHASE_COUNT-1:0][4:0] PHASE_LENGTHS =
    {5'd9, 5'd8, 5'd3, 5'd17, 5'd2, 5'd31, 5'd0, 5'd16, 5'd1};
  localparam logic [PHASE_COUNT-1:0][1:0] PHASE_ALPHABETS =
    {2'd2, 2'd3, 2'd2, 2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2};

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } text_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = 8'd0;
  logic                  in_end_of_book = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           out_line_matches;
  logic [31:0]           out_book_matches;
  logic                  out_book_done;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_pattern_occurrence_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_book   (in_end_of_book),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_matches (out_line_matches),
    .out_book_matches (out_book_matches),
    .out_book_done    (out_book_done),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Text bytes that wait to be driven, and results that the counter predicts.
  text_beat_t pending_text[$];
  result_t    expected_counts[$];
  text_beat_t next_beat;
  result_t    want_result;
  int         offered = 0;
  int         mismatches = 0;

  // Idle and stall rates in percent. They are changed only between phases.
  int         sender_gap_pct = 0;
  int         receiver_stall_pct = 0;
  logic       receiver_hold = 1'b0;
  logic       in_fire = 1'b0;
  event       hold_trigger;

  // Shadow copy of the configuration registers, as of reset.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = 5'd1;

  // Predictor state. Entry 0 of the window is the most recent byte. The free
  // count holds the bytes since the line start or since the last counted match.
  logic [7:0]  history [0:MAX_PATTERN-2];
  int unsigned unclaimed = 0;
  logic [15:0] line_count = '0;
  logic [31:0] book_total = '0;

  initial begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) history[i] = 8'd0;
  end

  function automatic logic [7:0] pattern_byte(input int unsigned i);
    logic [63:0] word;
    word = (i < 8) ? pat_lo : pat_hi;
    return word[(i % 8) * 8 +: 8];
  endfunction

  // A length of zero means one byte, and lengths above the maximum are clamped.
  function automatic int unsigned active_length();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return pat_len;
  endfunction

  // This task advances the line counter by one accepted byte. It queues the
  // result when the byte closes a line or a book. A newline is never compared
  // with the pattern. An end-of-book byte is scanned first and then closes
  // its partial line.
  task automatic count_byte(input logic [7:0] b, input logic eob);
    int unsigned len;
    logic        hit;
    result_t     res;
    if (b != NEWLINE_CODE) begin
      len = active_length();
      hit = (pattern_byte(len - 1) == b);
      for (int i = 0; i + 1 < len; i++) begin
        if (history[i] != pattern_byte(len - 2 - i)) hit = 1'b0;
      end
      for (int i = MAX_PATTERN - 2; i > 0; i--) history[i] = history[i - 1];
      history[0] = b;
      if (unclaimed < MAX_PATTERN) unclaimed++;
      // A match counts only if it does not overlap the previous counted match.
      if (hit && unclaimed >= len) begin
        unclaimed = 0;
        if (line_count != 16'hFFFF) line_count++;
        if (book_total != 32'hFFFF_FFFF) book_total++;
      end
    end
    if (b == NEWLINE_CODE || eob) begin
      res.line_matches = line_count;
      res.book_matches = book_total;
      res.book_done    = eob;
      expected_counts.push_back(res);
      unclaimed  = 0;
      line_count = '0;
      if (eob) book_total = '0;
    end
  endtask

  // Input driver. A new byte is offered only once the previous one has been
  // taken, so valid and the payload stay steady while the block stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_text.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        next_beat = pending_text.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= next_beat.data;
        in_end_of_book <= next_beat.eob;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !receiver_hold && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Input monitor. Each accepted byte goes straight into the predictor.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) count_byte(in_data_byte, in_end_of_book);
  end

  // Output monitor. Each result transaction is compared field by field with the
  // oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual line %0d book %0d done %0b",
                 $time, out_line_matches, out_book_matches, out_book_done);
      end else begin
        want_result = expected_counts.pop_front();
        if (out_line_matches !== want_result.line_matches) begin
          mismatches++;
          $display("%0t: line_matches: expected %0d, actual %0d",
                   $time, want_result.line_matches, out_line_matches);
        end
        if (out_book_matches !== want_result.book_matches) begin
          mismatches++;
          $display("%0t: book_matches: expected %0d, actual %0d",
                   $time, want_result.book_matches, out_book_matches);
        end
        if (out_book_done !== want_result.book_done) begin
          mismatches++;
          $display("%0t: book_done: expected %0b, actual %0b",
                   $time, want_result.book_done, out_book_done);
        end
      end
    end
  end

  // This process holds off the receiver for a long stretch. The output slot
  // fills up and the block has to stall its input while bytes keep coming.
  always begin
    @(hold_trigger);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  task automatic set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
      end
      FLOW_SENDER_GAPS: begin
        sender_gap_pct = 57;
        receiver_stall_pct = 0;
      end
      FLOW_RECEIVER_STALLS: begin
        sender_gap_pct = 0;
        receiver_stall_pct = 57;
      end
      default: begin
        sender_gap_pct = 27;
        receiver_stall_pct = 27;
      end
    endcase
  endtask

  // Register writes happen only while the block is idle. The shadow copy
  // follows each write, and writes to the unmapped index change nothing.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pat_lo = value;
      REG_PATTERN_HIGH: pat_hi = value;
      REG_PATTERN_LEN:  pat_len = value[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] text_byte(input int unsigned alphabet);
    return CHAR_A + 8'($urandom_range(0, alphabet - 1));
  endfunction

  // Pattern bytes come from a small alphabet so that the random text hits them
  // often. Now and then a byte is fully random. The bits above the length
  // field are random as well.
  task automatic load_pattern(input logic [4:0] len_code, input int unsigned alphabet);
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic [63:0]                 len_word;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      bytes[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : text_byte(alphabet);
    end
    len_word = {$urandom, $urandom};
    len_word[4:0] = len_code;
    write_reg(REG_PATTERN_LOW, bytes[7:0]);
    write_reg(REG_PATTERN_HIGH, bytes[15:8]);
    write_reg(REG_PATTERN_LEN, len_word);
  endtask

  task automatic offer(input logic [7:0] b, input logic eob);
    text_beat_t beat;
    beat.data = b;
    beat.eob  = eob;
    pending_text.push_back(beat);
    offered++;
  endtask

  // Most of the random text is copies of the pattern, some of them with one
  // bit flipped, and runs of alphabet bytes that overlap partial matches.
  // The rest is newlines and arbitrary bytes. The end of a book may fall on
  // any byte.
  task automatic offer_text(input int count, input int unsigned alphabet);
    int          target;
    int unsigned kind;
    int unsigned len;
    int unsigned flip_at;
    logic [7:0]  b;
    target = offered + count;
    while (offered < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = active_length();
        flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
          b = pattern_byte(i);
          if (i == flip_at) b = b ^ (8'd1 << $urandom_range(0, 7));
          offer(b, $urandom_range(0, 49) == 0);
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 6)) offer(text_byte(alphabet), $urandom_range(0, 49) == 0);
      end else if (kind < 88) begin
        offer(NEWLINE_CODE, $urandom_range(0, 19) == 0);
      end else begin
        offer(8'($urandom), $urandom_range(0, 29) == 0);
      end
    end
  endtask

  // This task waits until every byte has been taken and every predicted
  // result has arrived, plus a short settling time.
  task automatic wait_idle();
    while (pending_text.size() != 0 || in_valid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_flow(FLOW_FREE);

    // Directed part with the reset configuration: a one-byte pattern of zero.
    // It covers zero bytes as text, an empty line, and the end of a book on a
    // normal byte and on a newline.
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    offer(8'h00, 1'b0);
    offer(NEWLINE_CODE, 1'b0);
    offer(NEWLINE_CODE, 1'b0);
    offer(8'h00, 1'b1);
    offer(NEWLINE_CODE, 1'b1);
    offer(8'h80, 1'b1);
    wait_idle();

    // The unmapped index gets both values on every data bit and must be
    // ignored. Then the pattern "aba" checks that overlapping matches count
    // only once.
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED, 64'h0);
    write_reg(REG_PATTERN_LOW, {40'd0, CHAR_A, CHAR_B, CHAR_A});
    write_reg(REG_PATTERN_LEN, 64'd3);
    offer(CHAR_A, 1'b0);
    offer(CHAR_B, 1'b0);
    offer(CHAR_A, 1'b0);
    offer(CHAR_B, 1'b0);
    offer(CHAR_A, 1'b0);
    offer(NEWLINE_CODE, 1'b0);
    offer(CHAR_A, 1'b0);
    offer(CHAR_B, 1'b0);
    offer(CHAR_A, 1'b1);
    wait_idle();

    // Random phases. Each phase has its own pattern length and one of the four flow modes. In
    // the first phase the receiver is also held off for a long stretch.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_flow(flow_mode_t'(p % 4));
      load_pattern(PHASE_LENGTHS[p], PHASE_ALPHABETS[p]);
      offer_text(PHASE_ITEMS, PHASE_ALPHABETS[p]);
      if (p == 0) begin
        -> hold_trigger;
        offer_text(80, PHASE_ALPHABETS[p]);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
